>>> hdl/cu_pkg.sv
// Shared command/status types and exact small-divisor tables for the unranking block.
`timescale 1ns / 1ps
`default_nettype none

package cu_pkg;

	// Controller to datapath commands, at most one set per cycle
	typedef struct packed {
		logic load;    // capture rank and subset size
		logic setup;   // open the search window for the current position
		logic pick;    // take the midpoint and restart the binomial
		logic mul;     // form acc * factor and the bound rem * j
		logic step;    // keep the partial binomial, go to the next factor
		logic accept;  // candidate fits: raise lo
		logic reject;  // candidate too big: lower hi
		logic emit;    // load the output register, retire the position
	} cu_cmd_t;

	typedef struct packed {
		logic open;       // lo < hi, search not settled
		logic over;       // partial binomial above remaining rank
		logic step_last;  // last factor of the binomial
		logic pos_last;   // current position is 1
	} cu_sts_t;

	// Trailing zero count of a divisor 1..16
	function automatic logic [2:0] cu_tz(input logic [4:0] j);
		logic [2:0] r;
		case (j)
			5'd2, 5'd6, 5'd10, 5'd14: r = 3'd1;
			5'd4, 5'd12:              r = 3'd2;
			5'd8:                     r = 3'd3;
			5'd16:                    r = 3'd4;
			default:                  r = 3'd0;
		endcase
		return r;
	endfunction

	// Inverse of the odd part of a divisor 1..16, modulo 2^32
	function automatic logic [31:0] cu_inv(input logic [4:0] j);
		logic [31:0] r;
		case (j)
			5'd3, 5'd6, 5'd12: r = 32'hAAAA_AAAB;
			5'd5, 5'd10:       r = 32'hCCCC_CCCD;
			5'd7, 5'd14:       r = 32'hB6DB_6DB7;
			5'd9:              r = 32'h38E3_8E39;
			5'd11:             r = 32'hBA2E_8BA3;
			5'd13:             r = 32'hC4EC_4EC5;
			5'd15:             r = 32'hEEEE_EEEF;
			default:           r = 32'h0000_0001;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/cu_dp.sv
// Datapath: search window, binomial multiply / exact divide, remainder and output register.
`timescale 1ns / 1ps
`default_nettype none

module cu_dp #(
	parameter int RANK_BITS = 32,
	parameter int MAX_M     = 8
) (
	input  logic           clk,
	input  cu_pkg::cu_cmd_t cmd,
	output cu_pkg::cu_sts_t sts,
	input  logic [31:0]    rank,
	input  logic [3:0]     subset_size,
	output logic [2:0]     slot,
	output logic [31:0]    digit,
	output logic           last
);
	import cu_pkg::*;

	localparam int W  = (RANK_BITS < 32) ? RANK_BITS : 32;  // rank width in use
	localparam int CW = W + 1;                              // digit candidates
	localparam int IW = $clog2(MAX_M + 1);                  // position counter
	localparam int PW = W + CW;                             // acc * factor
	localparam int BW = W + IW;                             // rem * j

	logic [W-1:0]  rem_q, val_q, acc_q;
	logic [IW-1:0] i_q, j_q;
	logic          first_q;
	logic [CW-1:0] prev_q, lo_q, hi_q, c_q, fac_q;
	logic [PW-1:0] p_q;
	logic [BW-1:0] bj_q;
	logic [2:0]    slot_q;
	logic [31:0]   digit_q;
	logic          last_q;

	logic [IW-1:0] m_clamp;
	logic [CW-1:0] im1, lim, prev_m1, mid, span;
	logic [PW-1:0] shifted;
	logic [W-1:0]  inv_w, q;

	always_comb begin
		if (subset_size == 4'd0) begin
			m_clamp = IW'(1);
		end else if (32'(subset_size) > 32'(MAX_M)) begin
			m_clamp = IW'(MAX_M);
		end else begin
			m_clamp = IW'(subset_size);
		end
	end

	// Window for position i: [i-1, i-1+rem], capped below the previous digit
	assign im1     = CW'(i_q) - CW'(1);
	assign prev_m1 = prev_q - CW'(1);
	always_comb begin
		lim = im1 + CW'(rem_q);
		if (!first_q && prev_m1 < lim) begin
			lim = prev_m1;
		end
	end

	assign span = hi_q - lo_q + CW'(1);
	assign mid  = lo_q + (span >> 1);

	// Exact division of p by j: strip the power of two, multiply by the odd inverse
	// (the inverse modulo 2^W is the low W bits of the inverse modulo 2^32)
	assign shifted = p_q >> cu_tz(5'(j_q));
	assign inv_w   = W'(cu_inv(5'(j_q)));
	assign q       = shifted[W-1:0] * inv_w;

	assign sts.open      = lo_q < hi_q;
	assign sts.over      = p_q > PW'(bj_q);
	assign sts.step_last = j_q == i_q;
	assign sts.pos_last  = i_q == IW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q   <= rank[W-1:0];
			i_q     <= m_clamp;
			first_q <= 1'b1;
		end
		if (cmd.setup) begin
			if (i_q == IW'(1)) begin
				// C(c,1) = c, so the digit is the remainder itself
				lo_q  <= CW'(rem_q);
				hi_q  <= CW'(rem_q);
				val_q <= rem_q;
			end else begin
				lo_q  <= im1;
				hi_q  <= lim;
				val_q <= '0;
			end
		end
		if (cmd.pick) begin
			c_q   <= mid;
			acc_q <= W'(1);
			fac_q <= mid - CW'(i_q) + CW'(1);
			j_q   <= IW'(1);
		end
		if (cmd.mul) begin
			p_q  <= PW'(acc_q) * PW'(fac_q);
			bj_q <= BW'(rem_q) * BW'(j_q);
		end
		if (cmd.step) begin
			acc_q <= q;
			fac_q <= fac_q + CW'(1);
			j_q   <= j_q + IW'(1);
		end
		if (cmd.accept) begin
			lo_q  <= c_q;
			val_q <= q;
		end
		if (cmd.reject) begin
			hi_q <= c_q - CW'(1);
		end
		if (cmd.emit) begin
			slot_q  <= 3'(i_q - IW'(1));
			digit_q <= 32'(lo_q);
			last_q  <= i_q == IW'(1);
			rem_q   <= rem_q - val_q;
			prev_q  <= lo_q;
			first_q <= 1'b0;
			i_q     <= i_q - IW'(1);
		end
	end

	assign slot  = slot_q;
	assign digit = digit_q;
	assign last  = last_q;

endmodule

`default_nettype wire

>>> hdl/cu_ctrl.sv
// Controller: sequences positions, binary search iterations and binomial steps.
`timescale 1ns / 1ps
`default_nettype none

module cu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rank_valid,
	output logic            rank_ready,
	output logic            res_valid,
	input  logic            res_ready,
	input  cu_pkg::cu_sts_t sts,
	output cu_pkg::cu_cmd_t cmd
);
	import cu_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_PICK  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_CHK   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || res_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (rank_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_PICK;
			end
			ST_PICK: begin
				if (sts.open) begin
					cmd.pick = 1'b1;
					state_d  = ST_MUL;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				if (sts.over) begin
					cmd.reject = 1'b1;
					state_d    = ST_PICK;
				end else if (sts.step_last) begin
					cmd.accept = 1'b1;
					state_d    = ST_PICK;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.pos_last ? ST_IDLE : ST_SETUP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rank_ready = state_q == ST_IDLE;
	assign res_valid  = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/combination_unrank.sv
// Top level: combinadic unranking of a rank into subset_size decreasing digits.
// Per position i >= 2: setup, then one binary search iteration per halving of the window,
// each iteration a pick plus a multiply and a check per binomial factor (at most i); then emit.
// Position 1 needs no search. The window starts at rank+1 wide and then below the last digit.
// One rank is in work at a time; the next is taken once the last digit is in the output register.
// Reset (asynchronous, low) empties the controller and output and sets subset_size to 2.
`timescale 1ns / 1ps
`default_nettype none

module combination_unrank #(
	parameter int RANK_BITS = 32,
	parameter int MAX_M     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rank_valid,
	output logic        rank_ready,
	input  logic [31:0] rank,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  slot,
	output logic [31:0] digit,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cu_pkg::*;

	localparam logic REG_SUBSET_SIZE = 1'b0;  // register index, paddr[2]

	logic [3:0] subset_size_q;
	logic       cfg_wr;
	cu_cmd_t    cmd;
	cu_sts_t    sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && paddr[2] == REG_SUBSET_SIZE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subset_size_q <= 4'd2;
		end else if (cfg_wr) begin
			subset_size_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == REG_SUBSET_SIZE) ? {28'd0, subset_size_q} : 32'd0;

	cu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rank_valid (rank_valid),
		.rank_ready (rank_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	cu_dp #(
		.RANK_BITS (RANK_BITS),
		.MAX_M     (MAX_M)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.sts         (sts),
		.rank        (rank),
		.subset_size (subset_size_q),
		.slot        (slot),
		.digit       (digit),
		.last        (last)
	);

	// A taken rank keeps the block busy for at least the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(rank_valid && rank_ready) |=> !rank_ready)
		else $error("rank taken while a rank is still in work");

	// The final digit of a rank is always position 1
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last) |-> slot == 3'd0)
		else $error("last digit not at slot 0");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> subset_size_q == $past(pwdata[3:0]))
		else $error("subset_size write lost");

endmodule

`default_nettype wire

>>> tb/cu_digit_checker.sv
// Checker for combination_unrank: watches rank, result and config ports, predicts digits, compares.
`timescale 1ns / 1ps

module cu_digit_checker #(
	parameter int RANK_BITS = 32,
	parameter int MAX_M     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rank_valid,
	input  logic        rank_ready,
	input  logic [31:0] rank,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [2:0]  slot,
	input  logic [31:0] digit,
	input  logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	localparam int REG_SUBSET_SIZE = 0;
	localparam longint unsigned RANK_MASK = ((64'd1 << RANK_BITS) - 64'd1) & 64'hFFFF_FFFF;
	localparam longint unsigned BINOM_OVER = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]  slot;
		logic [31:0] digit;
		logic        last;
	} digit_t;

	digit_t     digit_q[$];
	logic [3:0] subset_size;
	digit_t     want;

	// C(c,k) for c >= k-1, or BINOM_OVER once a partial product passes bound
	function automatic longint unsigned binom_capped(input longint unsigned c,
			input longint unsigned k, input longint unsigned bound);
		longint unsigned acc, fac, j;
		if (c + 1 == k)
			return 0;
		acc = 1;
		for (j = 1; j <= k; j++) begin
			fac = c - k + j;
			if (acc > BINOM_OVER / fac)
				return BINOM_OVER;
			acc = acc * fac / j;
			if (acc > bound)
				return BINOM_OVER;
		end
		return acc;
	endfunction

	// Greedy combinadic split: per position, largest c with C(c,k) <= remainder
	task automatic unrank_rank(input logic [31:0] value);
		longint unsigned rem, lo, hi, mid, k, m;
		digit_t d;
		rem = value & RANK_MASK;
		if (subset_size == 0)
			m = 1;
		else if (subset_size > MAX_M)
			m = MAX_M;
		else
			m = 64'(subset_size);
		for (k = m; k >= 1; k--) begin
			lo = k - 1;
			hi = k - 1 + rem;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				if (binom_capped(mid, k, rem) == BINOM_OVER)
					hi = mid - 1;
				else
					lo = mid;
			end
			rem = rem - binom_capped(lo, k, rem);
			d.slot = 3'(k - 1);
			d.digit = lo[31:0];
			d.last = (k == 1);
			digit_q.push_back(d);
		end
	endtask

	task automatic note_fail(input string msg);
		fails++;
		if (fails <= 10)
			$display("[%0t] %s", $time, msg);
	endtask

	initial begin
		fails = 0;
		pending = 0;
		subset_size = 4'd2;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subset_size = 4'd2;
			digit_q.delete();
			pending = 0;
		end else begin
			if (rank_valid && rank_ready)
				unrank_rank(rank);
			if (res_valid && res_ready) begin
				if (digit_q.size() == 0) begin
					note_fail($sformatf("unexpected result: slot %0d digit %0d last %0d",
						slot, digit, last));
				end else begin
					want = digit_q.pop_front();
					if (slot !== want.slot || digit !== want.digit || last !== want.last)
						note_fail($sformatf({"result mismatch: expected slot %0d digit %0d ",
							"last %0d, got slot %0d digit %0d last %0d"},
							want.slot, want.digit, want.last, slot, digit, last));
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if ((paddr >> 2) == REG_SUBSET_SIZE)
						subset_size = pwdata[3:0];
				end else if ((paddr >> 2) == REG_SUBSET_SIZE &&
						prdata !== {28'd0, subset_size}) begin
					note_fail($sformatf("subset_size readback: expected %0d, got %0d",
						subset_size, prdata));
				end
			end
			pending = digit_q.size();
		end
	end

endmodule

>>> tb/tb.sv
// Testbench top for combination_unrank: drives ranks, config writes and result back-pressure.
`timescale 1ns / 1ps

module tb;

	localparam logic [2:0] ADDR_SUBSET_SIZE = 3'd0;
	localparam logic [2:0] ADDR_UNUSED      = 3'd4;
	localparam int         SETTLE_CYCLES    = 20;
	localparam int         LONG_HOLD        = 3000;
	localparam int         CYCLE_LIMIT      = 4_000_000;
	localparam int         RANDOM_PHASES    = 10;
	localparam int         ITEMS_PER_PHASE  = 50;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        rank_valid;
	logic        rank_ready;
	logic [31:0] rank;
	logic        res_valid;
	logic        res_ready;
	logic [2:0]  slot;
	logic [31:0] digit;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        hold_req;
	int          fails;
	int          pending;
	int unsigned cycles = 0;

	combination_unrank uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rank_valid(rank_valid),
		.rank_ready(rank_ready),
		.rank      (rank),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.slot      (slot),
		.digit     (digit),
		.last      (last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	cu_digit_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.rank_valid(rank_valid),
		.rank_ready(rank_ready),
		.rank      (rank),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.slot      (slot),
		.digit     (digit),
		.last      (last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: random stall modes, plus one long hold-off on request
	initial begin : rx_proc
		int unsigned mode, left;
		bit hold_done;
		mode = 0;
		left = 0;
		hold_done = 1'b0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				res_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(16, 96);
				end
				left--;
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					default: res_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_rank(input logic [31:0] value);
		@(negedge clk);
		rank_valid <= 1'b1;
		rank <= value;
		@(posedge clk);
		while (!rank_ready) @(posedge clk);
	endtask

	task automatic idle_gap(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			rank_valid <= 1'b0;
		end
	endtask

	// Wait until every expected digit is out and the block has gone quiet
	task automatic drain();
		@(negedge clk);
		rank_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write a register, then read subset_size back
	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_SUBSET_SIZE;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [31:0] rand_rank();
		logic [31:0] r;
		int unsigned w;
		case ($urandom_range(0, 7))
			0: r = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 3));
			1, 2: r = $urandom;
			default: begin
				w = $urandom_range(1, 24);
				r = $urandom & ((32'd1 << w) - 32'd1);
			end
		endcase
		return r;
	endfunction

	initial begin : stim
		int unsigned ph, left, burst;
		logic [3:0] size;
		arst_n = 1'b0;
		rank_valid = 1'b0;
		rank = 32'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_SUBSET_SIZE;
		pwdata = 32'd0;
		hold_req = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// size after reset is 2
		send_rank(32'd0);
		send_rank(32'd1);
		idle_gap(1);
		send_rank(32'd2);
		send_rank(32'hFFFF_FFFF);
		drain();

		// size 0 behaves as 1
		cfg_write(ADDR_SUBSET_SIZE, 32'd0);
		send_rank(32'd0);
		send_rank(32'hFFFF_FFFF);
		send_rank(32'd1);
		drain();

		// writes outside subset_size must not land
		cfg_write(ADDR_UNUSED, 32'd7);
		send_rank(32'd5);
		drain();

		// oversize clamps to MAX_M
		cfg_write(ADDR_SUBSET_SIZE, 32'hFFFF_FFFF);
		send_rank(32'd0);
		send_rank(32'hFFFF_FFFF);
		drain();

		cfg_write(ADDR_SUBSET_SIZE, 32'd8);
		send_rank(32'd0);
		send_rank(32'd8);
		idle_gap(2);
		send_rank(32'd9);
		send_rank(32'hFFFF_FFFF);
		send_rank(32'h8000_0000);
		drain();

		cfg_write(ADDR_SUBSET_SIZE, 32'd1);
		send_rank(32'hFFFF_FFFF);
		send_rank(32'd0);
		send_rank(32'h5555_5555);
		drain();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: size = 4'd1;
				1: size = 4'd8;
				2: size = 4'd15;
				3: size = 4'd0;
				4: size = 4'd3;
				default: size = 4'($urandom_range(0, 15));
			endcase
			cfg_write(ADDR_SUBSET_SIZE, {16'($urandom_range(0, 65535)), 12'd0, size});
			if (ph == 1)
				hold_req <= 1'b1;
			left = ITEMS_PER_PHASE;
			while (left > 0) begin
				burst = $urandom_range(1, 12);
				if (burst > left)
					burst = left;
				repeat (burst) send_rank(rand_rank());
				left -= burst;
				if ($urandom_range(0, 3) != 0)
					idle_gap($urandom_range(1, 20));
			end
			drain();
		end

		if (fails == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> sim.f
hdl/cu_pkg.sv
hdl/cu_dp.sv
hdl/cu_ctrl.sv
hdl/combination_unrank.sv
tb/cu_digit_checker.sv
tb/tb.sv
